/* rtl/core/sfdta_pkg.sv */
// ----------------------------------------------------------------------------
// sfdta_pkg: shared types and constants for the signed decimal formatter
// Holds the ASCII codes, the range limits, the reciprocals and the per-request flag bundle.
// ----------------------------------------------------------------------------
package sfdta_pkg;

  localparam int unsigned MagW = 14;  // magnitude 0 .. 9999
  localparam int unsigned QW   = 7;   // quotient / remainder by 100: 0 .. 99

  localparam logic signed [31:0] PosLimit = 32'sd10000;
  localparam logic signed [31:0] NegLimit = -32'sd10000;

  // reciprocal of 100: (x * 5243) >> 19 is exact for x below 43699
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned Recip100Sh = 19;
  // reciprocal of 10: (x * 103) >> 10 is exact for x below 179
  localparam logic [6:0] Recip10 = 7'd103;
  localparam int unsigned Recip10Sh = 10;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;

  // flags that travel beside the magnitude through the pipeline
  typedef struct packed {
    logic ovf_pos;
    logic ovf_neg;
    logic neg;
  } meta_t;

endpackage

/* rtl/core/sfdta_split.sv */
// ----------------------------------------------------------------------------
// sfdta_split: two-stage split of a magnitude into hundreds and remainder
// Stage A multiplies by the reciprocal of 100; stage B forms the remainder.
// ----------------------------------------------------------------------------
module sfdta_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  sfdta_pkg::meta_t              in_meta,
  input  logic [sfdta_pkg::MagW-1:0]    in_mag,
  output logic                          out_valid,
  output sfdta_pkg::meta_t              out_meta,
  output logic [sfdta_pkg::QW-1:0]      out_quo,
  output logic [sfdta_pkg::QW-1:0]      out_rem
);

  localparam int unsigned ProdW = sfdta_pkg::MagW + 13;

  logic                          va;
  sfdta_pkg::meta_t              meta_a;
  logic [sfdta_pkg::MagW-1:0]    mag_a;
  logic [sfdta_pkg::QW-1:0]      quo_a;
  logic [ProdW-1:0]              prod;
  logic [sfdta_pkg::MagW-1:0]    hund;
  logic [sfdta_pkg::MagW-1:0]    diff;

  assign prod = ProdW'(in_mag) * ProdW'(sfdta_pkg::Recip100);
  assign hund = sfdta_pkg::MagW'(quo_a) * sfdta_pkg::MagW'(7'd100);
  assign diff = mag_a - hund;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    meta_a   <= in_meta;
    mag_a    <= in_mag;
    quo_a    <= prod[sfdta_pkg::Recip100Sh +: sfdta_pkg::QW];
    out_meta <= meta_a;
    out_quo  <= quo_a;
    out_rem  <= diff[sfdta_pkg::QW-1:0];
  end

endmodule

/* rtl/core/signed_fixed_decimal_to_ascii.sv */
// ----------------------------------------------------------------------------
// signed_fixed_decimal_to_ascii: hundredths value to six ASCII characters
// One request accepted every cycle while reset is not held.
// The pipeline has four stages: range check, divide by 100,
// remainder, then divide by 10 and character forming.
// busy follows rst, so requests are refused only while reset is held.
// Synchronous reset clears the valid bits; no state persists between requests.
// ----------------------------------------------------------------------------
module signed_fixed_decimal_to_ascii (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [7:0]         char_pos0,
  output logic [7:0]         char_pos1,
  output logic [7:0]         char_pos2,
  output logic [7:0]         char_pos3,
  output logic [7:0]         char_pos4,
  output logic [7:0]         char_pos5
);

  localparam int unsigned MagW = sfdta_pkg::MagW;
  localparam int unsigned QW   = sfdta_pkg::QW;
  localparam int unsigned PW   = 2 * QW;

  // stage 1: range check, sign and magnitude
  logic                 accept;
  logic                 v1;
  sfdta_pkg::meta_t     meta1;
  sfdta_pkg::meta_t     meta_in;
  logic [MagW-1:0]      mag1;
  logic [31:0]          abs_val;

  // stage 2/3 lives in the split unit
  logic                 v3;
  sfdta_pkg::meta_t     meta3;
  logic [QW-1:0]        quo3;
  logic [QW-1:0]        rem3;

  // stage 4: digit extraction
  logic [PW-1:0]        quo_p;
  logic [PW-1:0]        rem_p;
  logic [3:0]           d_tens;
  logic [3:0]           d_unit;
  logic [3:0]           d_tenth;
  logic [3:0]           d_hund;
  logic [QW-1:0]        unit_w;
  logic [QW-1:0]        hund_w;
  logic [7:0]           c0_next, c1_next, c2_next, c4_next, c5_next;

  // the pipeline never backs up; refuse requests only while in reset
  assign busy   = rst;
  assign accept = start && !busy;

  assign meta_in.ovf_pos = !value[31] && (value >= sfdta_pkg::PosLimit);
  assign meta_in.ovf_neg =  value[31] && (value <= sfdta_pkg::NegLimit);
  assign meta_in.neg     =  value[31];
  assign abs_val = value[31] ? (~value + 32'd1) : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  // hold the magnitude only in its useful range; overflow cases ignore it
  always_ff @(posedge clk) begin
    meta1 <= meta_in;
    mag1  <= abs_val[MagW-1:0];
  end

  sfdta_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_meta   (meta1),
    .in_mag    (mag1),
    .out_valid (v3),
    .out_meta  (meta3),
    .out_quo   (quo3),
    .out_rem   (rem3)
  );

  // divide both halves by ten with the reciprocal, then take remainders
  assign quo_p   = PW'(quo3) * PW'(sfdta_pkg::Recip10);
  assign rem_p   = PW'(rem3) * PW'(sfdta_pkg::Recip10);
  assign d_tens  = quo_p[sfdta_pkg::Recip10Sh +: 4];
  assign d_tenth = rem_p[sfdta_pkg::Recip10Sh +: 4];
  assign unit_w  = quo3 - QW'(d_tens) * QW'(4'd10);
  assign hund_w  = rem3 - QW'(d_tenth) * QW'(4'd10);
  assign d_unit  = unit_w[3:0];
  assign d_hund  = hund_w[3:0];

  // form the characters; sign sits just before the first shown digit
  always_comb begin
    c0_next = sfdta_pkg::ChSpace;
    c1_next = sfdta_pkg::ChSpace;
    c2_next = sfdta_pkg::ChZero + {4'd0, d_unit};
    c4_next = sfdta_pkg::ChZero + {4'd0, d_tenth};
    c5_next = sfdta_pkg::ChZero + {4'd0, d_hund};
    if (meta3.ovf_pos || meta3.ovf_neg) begin
      c0_next = meta3.ovf_neg ? sfdta_pkg::ChMinus : sfdta_pkg::ChSpace;
      c1_next = sfdta_pkg::ChStar;
      c2_next = sfdta_pkg::ChStar;
      c4_next = sfdta_pkg::ChStar;
      c5_next = sfdta_pkg::ChStar;
    end else if (d_tens != 4'd0) begin
      c0_next = meta3.neg ? sfdta_pkg::ChMinus : sfdta_pkg::ChSpace;
      c1_next = sfdta_pkg::ChZero + {4'd0, d_tens};
    end else begin
      c1_next = meta3.neg ? sfdta_pkg::ChMinus : sfdta_pkg::ChSpace;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  // result registers: one cycle on the ports, marked by done
  always_ff @(posedge clk) begin
    char_pos0 <= c0_next;
    char_pos1 <= c1_next;
    char_pos2 <= c2_next;
    char_pos3 <= sfdta_pkg::ChDot;
    char_pos4 <= c4_next;
    char_pos5 <= c5_next;
  end

  // every result traces back to an accepted request
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("done without a matching request");

  // in range, the two low digits are decimal digits
  a_low_digits: assert property (@(posedge clk) disable iff (rst)
    (v3 && !meta3.ovf_pos && !meta3.ovf_neg) |-> (d_tenth <= 4'd9 && d_hund <= 4'd9))
    else $error("digit split out of range");

  // the two overflow flags never both hold
  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !(meta3.ovf_pos && meta3.ovf_neg))
    else $error("both overflow flags set");

  // a minus sign in position 0 is never followed by a blank in position 1
  a_sign_place: assert property (@(posedge clk) disable iff (rst)
    (done && char_pos0 == sfdta_pkg::ChMinus) |-> (char_pos1 != sfdta_pkg::ChSpace))
    else $error("minus sign placed before a blank");

endmodule
